// ----- sv/msif_pkg.sv -----
// Shared types, constants and a helper function for the submatrix and indexed fill block.
package msif_pkg;

  localparam int MAX_DIM   = 64;
  localparam int MAX_ELEMS = 4096;
  localparam int WORD_BITS = 32;

  localparam int DIM_W  = 7;
  localparam int IDX_W  = 13;
  localparam int ADDR_W = $clog2(MAX_ELEMS);
  localparam int CNT_W  = $clog2(MAX_ELEMS + 1);
  localparam int PROD_W = 2 * DIM_W;
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 7;

  localparam logic [2:0] REQ_BASE   = 3'd0;
  localparam logic [2:0] REQ_INDEX  = 3'd1;
  localparam logic [2:0] REQ_FILL   = 3'd2;
  localparam logic [2:0] REQ_SCALAR = 3'd3;
  localparam logic [2:0] REQ_READ   = 3'd4;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NO_BASE  = 3'd1;
  localparam logic [2:0] ST_BORDER   = 3'd2;
  localparam logic [2:0] ST_SHORT    = 3'd3;
  localparam logic [2:0] ST_LONG     = 3'd4;
  localparam logic [2:0] ST_ZERO_IDX = 3'd5;
  localparam logic [2:0] ST_SCALAR   = 3'd6;

  localparam logic [CFG_AW-1:0] CFG_FILL_MODE = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_BASE_ROWS = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_BASE_COLS = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_FILL_ROWS = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_FILL_COLS = 3'd4;
  localparam logic [CFG_AW-1:0] CFG_START_ROW = 3'd5;
  localparam logic [CFG_AW-1:0] CFG_START_COL = 3'd6;

  typedef struct packed {
    logic [2:0]           req_type;
    logic [WORD_BITS-1:0] elem_value;
    logic [IDX_W-1:0]     index_value;
    logic                 last_elem;
  } req_t;

  typedef struct packed {
    logic                 result_kind;
    logic [WORD_BITS-1:0] data_word;
    logic [2:0]           status_code;
    logic                 last_out;
  } res_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_CLR,
    OP_FILL_RD,
    OP_FILL_WR,
    OP_FILL_END,
    OP_REPORT,
    OP_SC_RD,
    OP_SC_WR,
    OP_RD_OUT
  } op_t;

  typedef struct packed {
    logic clr_done;
    logic fill_open;
    logic fill_last;
    logic fill_err;
    logic sc_ok;
    logic sc_last;
    logic present;
  } sts_t;

  function automatic logic [DIM_W-1:0] dim_clamp(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ----- sv/matrix_submatrix_and_indexed_fill.sv -----
// Top level of the submatrix and indexed fill block.
// Base, index and immediate status words appear in the cycle after acceptance; a readout
// passes through S_RD_OUT, a fill element S_FILL_RD and S_FILL_WR, a closing fill element
// also S_FILL_END and S_REPORT. Clearing the written map sweeps its memory one entry a
// cycle on the first fill element, on a discarded fill and before a scalar fill, which
// then writes each stored index in turn. Reset starts the same sweep with busy high.
module matrix_submatrix_and_indexed_fill (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  msif_pkg::req_t                req,
  output logic                          done,
  output msif_pkg::res_t                res,
  input  logic                          cfg_we,
  input  logic [msif_pkg::CFG_AW-1:0]   cfg_addr,
  input  logic [msif_pkg::CFG_DW-1:0]   cfg_data
);

  msif_pkg::op_t  op;
  msif_pkg::sts_t sts;

  msif_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .req_type(req.req_type),
    .sts(sts), .op(op), .busy(busy)
  );

  msif_dp u_dp (
    .clk(clk), .rst(rst), .op(op), .req(req),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
    .sts(sts), .done(done), .res(res)
  );

endmodule

// ----- sv/msif_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
module msif_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/msif_ctrl.sv -----
// Controller state machine sequencing accepts, map clearing, fills, scalar fills and readouts.
module msif_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [2:0]       req_type,
  input  msif_pkg::sts_t   sts,
  output msif_pkg::op_t    op,
  output logic             busy
);

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_FILL_RD,
    S_FILL_WR,
    S_FILL_END,
    S_REPORT,
    S_SC_RD,
    S_SC_WR,
    S_RD_OUT
  } state_t;

  typedef enum logic [1:0] {
    RET_IDLE,
    RET_FILL,
    RET_REPORT,
    RET_SC
  } ret_t;

  state_t state;
  ret_t   ret;

  assign busy = (state != S_IDLE);

  always_comb begin
    unique case (state)
      S_IDLE:     op = start ? msif_pkg::OP_ACCEPT : msif_pkg::OP_NONE;
      S_CLR:      op = msif_pkg::OP_CLR;
      S_FILL_RD:  op = msif_pkg::OP_FILL_RD;
      S_FILL_WR:  op = msif_pkg::OP_FILL_WR;
      S_FILL_END: op = msif_pkg::OP_FILL_END;
      S_REPORT:   op = msif_pkg::OP_REPORT;
      S_SC_RD:    op = msif_pkg::OP_SC_RD;
      S_SC_WR:    op = msif_pkg::OP_SC_WR;
      S_RD_OUT:   op = msif_pkg::OP_RD_OUT;
      default:    op = msif_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      ret   <= RET_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            unique case (req_type)
              msif_pkg::REQ_FILL: begin
                if (sts.fill_open) begin
                  state <= S_FILL_RD;
                end else begin
                  state <= S_CLR;
                  ret   <= RET_FILL;
                end
              end
              msif_pkg::REQ_SCALAR: begin
                if (sts.sc_ok) begin
                  state <= S_CLR;
                  ret   <= RET_SC;
                end
              end
              msif_pkg::REQ_READ: begin
                if (sts.present) begin
                  state <= S_RD_OUT;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_CLR: begin
          if (sts.clr_done) begin
            unique case (ret)
              RET_IDLE:   state <= S_IDLE;
              RET_FILL:   state <= S_FILL_RD;
              RET_REPORT: state <= S_REPORT;
              RET_SC:     state <= S_SC_RD;
              default:    state <= S_IDLE;
            endcase
          end
        end
        S_FILL_RD: state <= S_FILL_WR;
        S_FILL_WR: state <= sts.fill_last ? S_FILL_END : S_IDLE;
        S_FILL_END: begin
          if (sts.fill_err) begin
            state <= S_CLR;
            ret   <= RET_REPORT;
          end else begin
            state <= S_REPORT;
          end
        end
        S_REPORT: state <= S_IDLE;
        S_SC_RD:  state <= S_SC_WR;
        S_SC_WR:  state <= sts.sc_last ? S_IDLE : S_SC_RD;
        S_RD_OUT: state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- sv/msif_dp.sv -----
// Datapath: configuration registers, counters, element memories, fill addressing and results.
module msif_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  msif_pkg::op_t                 op,
  input  msif_pkg::req_t                req,
  input  logic                          cfg_we,
  input  logic [msif_pkg::CFG_AW-1:0]   cfg_addr,
  input  logic [msif_pkg::CFG_DW-1:0]   cfg_data,
  output msif_pkg::sts_t                sts,
  output logic                          done,
  output msif_pkg::res_t                res
);

  localparam int DW = msif_pkg::DIM_W;
  localparam int AW = msif_pkg::ADDR_W;
  localparam int CW = msif_pkg::CNT_W;
  localparam int IW = msif_pkg::IDX_W;
  localparam int PW = msif_pkg::PROD_W;
  localparam int WB = msif_pkg::WORD_BITS;
  localparam int ME = msif_pkg::MAX_ELEMS;

  logic          mode;
  logic [DW-1:0] c_br, c_bc, c_fr, c_fc, c_sr, c_sc;

  logic [CW-1:0] base_count, index_count, fill_count;
  logic [IW-1:0] max_idx;
  logic          base_valid, base_open, index_open, fill_open;
  logic [DW-1:0] rowpos, colpos;
  logic [AW-1:0] read_pointer, clr_addr, k;
  msif_pkg::req_t rq;
  logic [2:0]    res_st;
  logic          rfin;

  logic [DW-1:0] br, bc, fr, fc, sr, sc;
  logic [PW-1:0] bprod, fsize;
  logic [CW-1:0] bsize;
  logic          present, border;
  logic [2:0]    sc_st, fill_st;
  logic [AW-1:0] rp_eff;
  logic          rd_fin;
  logic [CW-1:0] bcur, icur, bnext;
  logic [IW-1:0] mcur;
  logic          bwr, iwr;
  logic [DW:0]   rsum, csum;
  logic [PW:0]   saddr;
  logic          sub_wr, ind_wr, idx_ok;
  logic [IW-1:0] i_rd;
  logic [AW-1:0] ind_addr;
  logic          acc_base, acc_idx, acc_fill, acc_sc, acc_rd;

  logic          base_we, idx_we, ovl_we, map_we, map_wd, map_rd;
  logic [AW-1:0] idx_raddr, ovl_waddr, map_waddr;
  logic [WB-1:0] base_rd, ovl_rd;

  logic           done_next;
  msif_pkg::res_t res_next;

  assign br = msif_pkg::dim_clamp(c_br);
  assign bc = msif_pkg::dim_clamp(c_bc);
  assign fr = msif_pkg::dim_clamp(c_fr);
  assign fc = msif_pkg::dim_clamp(c_fc);
  assign sr = msif_pkg::dim_clamp(c_sr);
  assign sc = msif_pkg::dim_clamp(c_sc);

  assign bprod   = PW'(br) * PW'(bc);
  assign fsize   = PW'(fr) * PW'(fc);
  assign bsize   = (bprod > PW'(ME)) ? CW'(ME) : CW'(bprod);
  assign present = base_valid && (base_count >= bsize);
  assign border  = ((DW+1)'(sr) + (DW+1)'(fr) - (DW+1)'(1) > (DW+1)'(br)) ||
                   ((DW+1)'(sc) + (DW+1)'(fc) - (DW+1)'(1) > (DW+1)'(bc));

  always_comb begin
    if (!mode) begin
      sc_st = msif_pkg::ST_SCALAR;
    end else if (CW'(max_idx) > bsize) begin
      sc_st = msif_pkg::ST_BORDER;
    end else if (!present) begin
      sc_st = msif_pkg::ST_NO_BASE;
    end else if (index_count == '0) begin
      sc_st = msif_pkg::ST_ZERO_IDX;
    end else begin
      sc_st = msif_pkg::ST_OK;
    end
  end

  always_comb begin
    fill_st = msif_pkg::ST_OK;
    if (!mode) begin
      if (PW'(fill_count) < fsize) begin
        fill_st = msif_pkg::ST_SHORT;
      end else if (border) begin
        fill_st = msif_pkg::ST_BORDER;
      end else if (!present) begin
        fill_st = msif_pkg::ST_NO_BASE;
      end
    end else begin
      if (fill_count > index_count) begin
        fill_st = msif_pkg::ST_LONG;
      end else if (fill_count < index_count) begin
        fill_st = msif_pkg::ST_SHORT;
      end else if (CW'(max_idx) > bsize) begin
        fill_st = msif_pkg::ST_BORDER;
      end else if (!present) begin
        fill_st = msif_pkg::ST_NO_BASE;
      end
    end
  end

  assign rp_eff = ({1'b0, read_pointer} >= bsize) ? '0 : read_pointer;
  assign rd_fin = ({1'b0, rp_eff} + CW'(1)) == bsize;

  assign bcur  = base_open ? base_count : '0;
  assign bwr   = bcur < CW'(ME);
  assign bnext = bwr ? bcur + CW'(1) : bcur;
  assign icur  = index_open ? index_count : '0;
  assign mcur  = index_open ? max_idx : '0;
  assign iwr   = (req.index_value != '0) && (icur < CW'(ME));

  assign rsum   = (DW+1)'(sr) - (DW+1)'(1) + (DW+1)'(rowpos);
  assign csum   = (DW+1)'(sc) - (DW+1)'(1) + (DW+1)'(colpos);
  assign saddr  = (PW+1)'(rsum) * (PW+1)'(bc) + (PW+1)'(csum);
  assign sub_wr = (rowpos < fr) && (colpos < fc) && !border && (saddr < (PW+1)'(ME));

  assign idx_ok   = (i_rd >= IW'(1)) && (CW'(i_rd) <= CW'(ME));
  assign ind_addr = AW'(i_rd - IW'(1));
  assign ind_wr   = (fill_count < index_count) && idx_ok;

  assign acc_base = (op == msif_pkg::OP_ACCEPT) && (req.req_type == msif_pkg::REQ_BASE);
  assign acc_idx  = (op == msif_pkg::OP_ACCEPT) && (req.req_type == msif_pkg::REQ_INDEX);
  assign acc_fill = (op == msif_pkg::OP_ACCEPT) && (req.req_type == msif_pkg::REQ_FILL);
  assign acc_sc   = (op == msif_pkg::OP_ACCEPT) && (req.req_type == msif_pkg::REQ_SCALAR);
  assign acc_rd   = (op == msif_pkg::OP_ACCEPT) && (req.req_type == msif_pkg::REQ_READ);

  assign base_we   = acc_base && bwr;
  assign idx_we    = acc_idx && iwr;
  assign idx_raddr = (op == msif_pkg::OP_SC_RD) ? k : fill_count[AW-1:0];
  assign ovl_we    = ((op == msif_pkg::OP_FILL_WR) && (mode ? ind_wr : sub_wr)) ||
                     ((op == msif_pkg::OP_SC_WR) && idx_ok);
  assign ovl_waddr = ((op == msif_pkg::OP_FILL_WR) && !mode) ? saddr[AW-1:0] : ind_addr;
  assign map_we    = ovl_we || (op == msif_pkg::OP_CLR);
  assign map_waddr = (op == msif_pkg::OP_CLR) ? clr_addr : ovl_waddr;
  assign map_wd    = (op != msif_pkg::OP_CLR);

  msif_ram #(.WIDTH(WB), .DEPTH(ME)) u_base (
    .clk(clk), .we(base_we), .waddr(bcur[AW-1:0]), .wdata(req.elem_value),
    .raddr(rp_eff), .rdata(base_rd)
  );

  msif_ram #(.WIDTH(IW), .DEPTH(ME)) u_idx (
    .clk(clk), .we(idx_we), .waddr(icur[AW-1:0]), .wdata(req.index_value),
    .raddr(idx_raddr), .rdata(i_rd)
  );

  msif_ram #(.WIDTH(WB), .DEPTH(ME)) u_ovl (
    .clk(clk), .we(ovl_we), .waddr(ovl_waddr), .wdata(rq.elem_value),
    .raddr(rp_eff), .rdata(ovl_rd)
  );

  msif_ram #(.WIDTH(1), .DEPTH(ME)) u_map (
    .clk(clk), .we(map_we), .waddr(map_waddr), .wdata(map_wd),
    .raddr(rp_eff), .rdata(map_rd)
  );

  assign sts.clr_done  = (clr_addr == AW'(ME - 1));
  assign sts.fill_open = fill_open;
  assign sts.fill_last = rq.last_elem;
  assign sts.fill_err  = (fill_st != msif_pkg::ST_OK);
  assign sts.sc_ok     = (sc_st == msif_pkg::ST_OK);
  assign sts.sc_last   = ({1'b0, k} + CW'(1)) >= index_count;
  assign sts.present   = present;

  always_comb begin
    done_next = 1'b0;
    res_next  = '0;
    if (acc_base && req.last_elem) begin
      done_next            = 1'b1;
      res_next.status_code = (bnext >= bsize) ? msif_pkg::ST_OK : msif_pkg::ST_SHORT;
    end
    if (acc_idx && req.last_elem) begin
      done_next            = 1'b1;
      res_next.status_code = (iwr || icur != '0) ? msif_pkg::ST_OK : msif_pkg::ST_ZERO_IDX;
    end
    if (acc_sc && sc_st != msif_pkg::ST_OK) begin
      done_next            = 1'b1;
      res_next.status_code = sc_st;
    end
    if (acc_rd && !present) begin
      done_next            = 1'b1;
      res_next.status_code = msif_pkg::ST_NO_BASE;
    end
    if (op == msif_pkg::OP_REPORT) begin
      done_next            = 1'b1;
      res_next.status_code = res_st;
    end
    if (op == msif_pkg::OP_SC_WR && sts.sc_last) begin
      done_next            = 1'b1;
      res_next.status_code = msif_pkg::ST_OK;
    end
    if (op == msif_pkg::OP_RD_OUT) begin
      done_next            = 1'b1;
      res_next.result_kind = 1'b1;
      res_next.data_word   = map_rd ? ovl_rd : base_rd;
      res_next.last_out    = rfin;
    end
  end

  always_ff @(posedge clk) begin
    if (op == msif_pkg::OP_ACCEPT) begin
      rq <= req;
    end
    if (op == msif_pkg::OP_FILL_END) begin
      res_st <= fill_st;
    end
    if (acc_rd) begin
      rfin <= rd_fin;
    end

    if (rst) begin
      mode         <= 1'b0;
      c_br         <= DW'(1);
      c_bc         <= DW'(1);
      c_fr         <= DW'(1);
      c_fc         <= DW'(1);
      c_sr         <= DW'(1);
      c_sc         <= DW'(1);
      base_count   <= '0;
      index_count  <= '0;
      fill_count   <= '0;
      max_idx      <= '0;
      base_valid   <= 1'b0;
      base_open    <= 1'b0;
      index_open   <= 1'b0;
      fill_open    <= 1'b0;
      rowpos       <= '0;
      colpos       <= '0;
      read_pointer <= '0;
      clr_addr     <= '0;
      k            <= '0;
      done         <= 1'b0;
      res          <= '0;
    end else begin
      done <= done_next;
      res  <= res_next;

      if (cfg_we) begin
        case (cfg_addr)
          msif_pkg::CFG_FILL_MODE: mode <= cfg_data[0];
          msif_pkg::CFG_BASE_ROWS: c_br <= cfg_data;
          msif_pkg::CFG_BASE_COLS: c_bc <= cfg_data;
          msif_pkg::CFG_FILL_ROWS: c_fr <= cfg_data;
          msif_pkg::CFG_FILL_COLS: c_fc <= cfg_data;
          msif_pkg::CFG_START_ROW: c_sr <= cfg_data;
          msif_pkg::CFG_START_COL: c_sc <= cfg_data;
          default: ;
        endcase
      end

      if (op == msif_pkg::OP_ACCEPT || op == msif_pkg::OP_FILL_END) begin
        clr_addr <= '0;
      end else if (op == msif_pkg::OP_CLR) begin
        clr_addr <= clr_addr + AW'(1);
      end

      if (acc_base) begin
        base_count <= bnext;
        if (req.last_elem) begin
          base_open  <= 1'b0;
          base_valid <= bnext >= bsize;
        end else begin
          base_open  <= 1'b1;
          base_valid <= base_open ? base_valid : 1'b0;
        end
      end

      if (acc_idx) begin
        index_count <= iwr ? icur + CW'(1) : icur;
        max_idx     <= (iwr && req.index_value > mcur) ? req.index_value : mcur;
        index_open  <= !req.last_elem;
      end

      if (acc_fill && !fill_open) begin
        fill_open    <= 1'b1;
        fill_count   <= '0;
        rowpos       <= '0;
        colpos       <= '0;
        read_pointer <= '0;
      end

      if (acc_sc) begin
        fill_open <= 1'b0;
        k         <= '0;
      end

      if (acc_rd && present) begin
        read_pointer <= rd_fin ? '0 : rp_eff + AW'(1);
      end

      if (op == msif_pkg::OP_FILL_WR) begin
        if (!mode && rowpos < fr) begin
          if (colpos + DW'(1) >= fc) begin
            colpos <= '0;
            rowpos <= rowpos + DW'(1);
          end else begin
            colpos <= colpos + DW'(1);
          end
        end
        if (fill_count <= CW'(ME)) begin
          fill_count <= fill_count + CW'(1);
        end
      end

      if (op == msif_pkg::OP_FILL_END) begin
        fill_open <= 1'b0;
      end

      if (op == msif_pkg::OP_SC_WR) begin
        k <= k + AW'(1);
        if (sts.sc_last) begin
          read_pointer <= '0;
        end
      end
    end
  end

endmodule

// ----- sv/msif_chk.sv -----
// Port-level checker for the submatrix and indexed fill block, with its bind.
module msif_chk (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input logic           done,
  input msif_pkg::res_t res
);

  a_reset_quiet: assert property (@(posedge clk) $past(rst) |-> !done)
    else $error("result word shown straight after reset");

  a_reset_sweep: assert property (@(posedge clk) $past(rst) |-> busy)
    else $error("block not busy clearing after reset");

  a_status_clean: assert property (@(posedge clk) disable iff (rst)
    (done && !res.result_kind) |-> (res.data_word == '0 && !res.last_out))
    else $error("status word carries data");

  a_data_clean: assert property (@(posedge clk) disable iff (rst)
    (done && res.result_kind) |-> (res.status_code == msif_pkg::ST_OK))
    else $error("readout word carries a status");

  a_caused: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy || start))
    else $error("result word without a word accepted or work in progress");

endmodule

bind matrix_submatrix_and_indexed_fill msif_chk u_msif_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .res(res)
);

// ----- test/tb_top.sv -----
// Self-checking testbench for the submatrix and indexed fill block.
module tb_top;
  import msif_pkg::*;

  localparam int CYCLE_LIMIT = 40000000;
  localparam int ITEM_TARGET = 800;

  typedef struct {
    req_t r;
    bit   chk;
    res_t exp;
  } drow_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  req_t              req = '0;
  logic              done;
  res_t              res;
  logic              cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [CFG_DW-1:0] cfg_data = '0;

  matrix_submatrix_and_indexed_fill uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req), .done(done), .res(res),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  logic [31:0] base_mem [MAX_ELEMS];
  logic [31:0] ovl_mem [MAX_ELEMS];
  bit          wmap [MAX_ELEMS];
  int          idx_mem [MAX_ELEMS];
  int          base_cnt, idx_cnt, idx_max, fill_cnt, pos_r, pos_c, rd_ptr;
  bit          base_ok, base_open, idx_open, fill_open;
  int          m_mode, b_rows, b_cols, f_rows, f_cols, s_row, s_col;

  res_t        pending_words [$];
  int          errors = 0;
  int          cycles = 0;
  int          items = 0;
  drow_t       drows [$];

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL matrix_submatrix_and_indexed_fill");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_words.size() == 0) begin
        errors++;
        $display("%0t unexpected word kind=%0d data=%h st=%0d last=%0d", $time,
                 res.result_kind, res.data_word, res.status_code, res.last_out);
      end else begin
        res_t e;
        e = pending_words.pop_front();
        if (res.result_kind !== e.result_kind || res.data_word !== e.data_word ||
            res.status_code !== e.status_code || res.last_out !== e.last_out) begin
          errors++;
          $display("%0t mismatch exp kind=%0d data=%h st=%0d last=%0d got kind=%0d data=%h st=%0d last=%0d",
                   $time, e.result_kind, e.data_word, e.status_code, e.last_out,
                   res.result_kind, res.data_word, res.status_code, res.last_out);
        end
      end
    end
  end

  function automatic int dimc(int v);
    if (v < 1) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  function automatic int bsize();
    int s;
    s = dimc(b_rows) * dimc(b_cols);
    return (s > MAX_ELEMS) ? MAX_ELEMS : s;
  endfunction

  function automatic bit border_err();
    return (dimc(s_row) + dimc(f_rows) - 1 > dimc(b_rows)) ||
           (dimc(s_col) + dimc(f_cols) - 1 > dimc(b_cols));
  endfunction

  function automatic bit have_base();
    return base_ok && base_cnt >= bsize();
  endfunction

  function automatic req_t mk(logic [2:0] t, logic [31:0] v, logic [12:0] i, logic l);
    req_t r;
    r.req_type = t;
    r.elem_value = v;
    r.index_value = i;
    r.last_elem = l;
    return r;
  endfunction

  task automatic clear_map();
    foreach (wmap[k]) wmap[k] = 1'b0;
  endtask

  task automatic compute_fill_result(input req_t r, output bit got, output res_t o);
    int addr, t, sz, k;
    logic [2:0] st;
    got = 1'b0;
    o = '0;
    case (r.req_type)
      REQ_BASE: begin
        if (!base_open) begin
          base_open = 1; base_cnt = 0; base_ok = 0;
        end
        if (base_cnt < MAX_ELEMS) begin
          base_mem[base_cnt] = r.elem_value;
          base_cnt++;
        end
        if (r.last_elem) begin
          base_open = 0;
          base_ok = base_cnt >= bsize();
          got = 1;
          o.status_code = base_ok ? ST_OK : ST_SHORT;
        end
      end
      REQ_INDEX: begin
        if (!idx_open) begin
          idx_open = 1; idx_cnt = 0; idx_max = 0;
        end
        t = r.index_value;
        if (t != 0 && idx_cnt < MAX_ELEMS) begin
          idx_mem[idx_cnt] = t;
          idx_cnt++;
          if (t > idx_max) idx_max = t;
        end
        if (r.last_elem) begin
          idx_open = 0;
          got = 1;
          o.status_code = (idx_cnt == 0) ? ST_ZERO_IDX : ST_OK;
        end
      end
      REQ_FILL: begin
        if (!fill_open) begin
          fill_open = 1;
          clear_map();
          fill_cnt = 0; pos_r = 0; pos_c = 0; rd_ptr = 0;
        end
        if (m_mode == 0) begin
          if (pos_r < dimc(f_rows) && pos_c < dimc(f_cols) && !border_err()) begin
            addr = (dimc(s_row) - 1 + pos_r) * dimc(b_cols) + (dimc(s_col) - 1 + pos_c);
            if (addr < MAX_ELEMS) begin
              ovl_mem[addr] = r.elem_value;
              wmap[addr] = 1'b1;
            end
          end
          if (pos_r < dimc(f_rows)) begin
            pos_c++;
            if (pos_c >= dimc(f_cols)) begin
              pos_c = 0; pos_r++;
            end
          end
        end else if (fill_cnt < idx_cnt) begin
          t = idx_mem[fill_cnt];
          if (t >= 1 && t <= MAX_ELEMS) begin
            ovl_mem[t-1] = r.elem_value;
            wmap[t-1] = 1'b1;
          end
        end
        if (fill_cnt <= MAX_ELEMS) fill_cnt++;
        if (r.last_elem) begin
          fill_open = 0;
          if (m_mode == 0 && fill_cnt < dimc(f_rows) * dimc(f_cols)) st = ST_SHORT;
          else if (m_mode == 0 && border_err()) st = ST_BORDER;
          else if (m_mode != 0 && fill_cnt > idx_cnt) st = ST_LONG;
          else if (m_mode != 0 && fill_cnt < idx_cnt) st = ST_SHORT;
          else if (m_mode != 0 && idx_max > bsize()) st = ST_BORDER;
          else if (!have_base()) st = ST_NO_BASE;
          else st = ST_OK;
          if (st != ST_OK) clear_map();
          got = 1;
          o.status_code = st;
        end
      end
      REQ_SCALAR: begin
        fill_open = 0;
        got = 1;
        if (m_mode == 0) o.status_code = ST_SCALAR;
        else if (idx_max > bsize()) o.status_code = ST_BORDER;
        else if (!have_base()) o.status_code = ST_NO_BASE;
        else if (idx_cnt == 0) o.status_code = ST_ZERO_IDX;
        else begin
          clear_map();
          for (k = 0; k < idx_cnt && k < MAX_ELEMS; k++) begin
            t = idx_mem[k];
            if (t >= 1 && t <= MAX_ELEMS) begin
              ovl_mem[t-1] = r.elem_value;
              wmap[t-1] = 1'b1;
            end
          end
          rd_ptr = 0;
          o.status_code = ST_OK;
        end
      end
      REQ_READ: begin
        got = 1;
        if (!have_base()) o.status_code = ST_NO_BASE;
        else begin
          sz = bsize();
          if (rd_ptr >= sz) rd_ptr = 0;
          o.result_kind = 1'b1;
          o.data_word = wmap[rd_ptr] ? ovl_mem[rd_ptr] : base_mem[rd_ptr];
          o.last_out = (rd_ptr + 1 == sz);
          rd_ptr = o.last_out ? 0 : rd_ptr + 1;
        end
      end
      default: ;
    endcase
  endtask

  task automatic send(input req_t r, output bit got, output res_t o);
    start <= 1'b1;
    req <= r;
    do @(posedge clk); while (busy);
    compute_fill_result(r, got, o);
    if (got) pending_words.push_back(o);
    items++;
    if (!(items >= 300 && items < 420) && $urandom_range(0, 99) < 17) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic put(input req_t r);
    bit got;
    res_t o;
    send(r, got, o);
  endtask

  task automatic settle();
    start <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic int pick_dim();
    int p;
    p = $urandom_range(0, 99);
    if (p < 65) return $urandom_range(1, 4);
    if (p < 78) return $urandom_range(5, 8);
    if (p < 88) return MAX_DIM;
    if (p < 94) return 0;
    return 127;
  endfunction

  task automatic configure();
    int v [7];
    v[0] = $urandom_range(0, 1);
    v[1] = pick_dim(); v[2] = pick_dim();
    if (dimc(v[1]) * dimc(v[2]) > MAX_DIM) v[2] = $urandom_range(1, 2);
    v[3] = pick_dim(); v[4] = pick_dim();
    if (dimc(v[3]) * dimc(v[4]) > MAX_DIM) v[4] = 1;
    v[5] = ($urandom_range(0, 3) == 0) ? pick_dim() : $urandom_range(1, 2);
    v[6] = ($urandom_range(0, 3) == 0) ? pick_dim() : $urandom_range(1, 2);
    for (int a = 0; a < 7; a++) begin
      cfg_we <= 1'b1;
      cfg_addr <= CFG_AW'(a);
      cfg_data <= CFG_DW'(v[a]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    m_mode = v[0] & 1;
    b_rows = v[1]; b_cols = v[2]; f_rows = v[3]; f_cols = v[4]; s_row = v[5]; s_col = v[6];
  endtask

  task automatic run_phase();
    int sz, n, p;
    logic [12:0] iv;
    configure();
    sz = bsize();
    if ($urandom_range(0, 99) < 85) begin
      p = $urandom_range(0, 9);
      n = (p == 0 && sz > 1) ? sz - 1 : (p == 1) ? sz + 1 : sz;
      for (int k = 0; k < n; k++) put(mk(REQ_BASE, $urandom, $urandom, k == n - 1));
    end
    if (m_mode == 1 || $urandom_range(0, 2) == 0) begin
      n = $urandom_range(1, (sz < 8) ? sz + 1 : 8);
      for (int k = 0; k < n; k++) begin
        p = $urandom_range(0, 99);
        if (p < 85) iv = $urandom_range(1, sz);
        else if (p < 91) iv = 0;
        else if (p < 96) iv = $urandom_range(1, MAX_ELEMS);
        else iv = $urandom;
        put(mk(REQ_INDEX, $urandom, iv, k == n - 1));
      end
    end
    if (m_mode == 0) n = dimc(f_rows) * dimc(f_cols);
    else n = (idx_cnt == 0) ? 1 : idx_cnt;
    p = $urandom_range(0, 9);
    if (p == 0 && n > 1) n--;
    else if (p == 1) n++;
    for (int k = 0; k < n; k++) put(mk(REQ_FILL, $urandom, $urandom, k == n - 1));
    if ($urandom_range(0, 2) == 0) put(mk(REQ_SCALAR, $urandom, $urandom, $urandom));
    n = sz + $urandom_range(0, 3);
    if (n > 70) n = 70;
    for (int k = 0; k < n; k++) put(mk(REQ_READ, $urandom, $urandom, $urandom));
    repeat ($urandom_range(0, 2)) put(mk($urandom_range(0, 7), $urandom, $urandom, $urandom));
    settle();
  endtask

  task automatic add(input req_t r, input bit chk, input res_t exp);
    drow_t d;
    d.r = r;
    d.chk = chk;
    d.exp = exp;
    drows.push_back(d);
  endtask

  initial begin
    bit got;
    res_t o;
    base_cnt = 0; idx_cnt = 0; idx_max = 0; fill_cnt = 0;
    pos_r = 0; pos_c = 0; rd_ptr = 0;
    base_ok = 0; base_open = 0; idx_open = 0; fill_open = 0;
    m_mode = 0; b_rows = 1; b_cols = 1; f_rows = 1; f_cols = 1; s_row = 1; s_col = 1;
    clear_map();

    add(mk(REQ_READ, 32'h0, 13'h0, 1'b0), 1, '{1'b0, 32'h0, ST_NO_BASE, 1'b0});
    add(mk(REQ_SCALAR, 32'h1234, 13'h0, 1'b1), 1, '{1'b0, 32'h0, ST_SCALAR, 1'b0});
    add(mk(REQ_INDEX, 32'h0, 13'h0, 1'b1), 1, '{1'b0, 32'h0, ST_ZERO_IDX, 1'b0});
    add(mk(REQ_FILL, 32'h5, 13'h0, 1'b1), 1, '{1'b0, 32'h0, ST_NO_BASE, 1'b0});
    add(mk(REQ_BASE, 32'hFFFFFFFF, 13'h1FFF, 1'b1), 1, '{1'b0, 32'h0, ST_OK, 1'b0});
    add(mk(REQ_READ, 32'hFFFFFFFF, 13'h1FFF, 1'b1), 1, '{1'b1, 32'hFFFFFFFF, ST_OK, 1'b1});
    add(mk(REQ_FILL, 32'h0, 13'h1FFF, 1'b1), 1, '{1'b0, 32'h0, ST_OK, 1'b0});
    add(mk(REQ_READ, 32'h0, 13'h0, 1'b0), 1, '{1'b1, 32'h0, ST_OK, 1'b1});
    add(mk(3'd5, 32'hFFFFFFFF, 13'h1FFF, 1'b1), 0, '0);
    add(mk(3'd6, 32'h0, 13'h0, 1'b0), 0, '0);
    add(mk(3'd7, 32'hA5A5A5A5, 13'h0AAA, 1'b1), 0, '0);
    add(mk(REQ_INDEX, 32'h0, 13'd4096, 1'b0), 0, '0);
    add(mk(REQ_INDEX, 32'h0, 13'h1FFF, 1'b0), 0, '0);
    add(mk(REQ_INDEX, 32'h0, 13'd1, 1'b1), 0, '0);
    add(mk(REQ_FILL, 32'hA5A5A5A5, 13'h0, 1'b0), 0, '0);
    add(mk(REQ_FILL, 32'h5A5A5A5A, 13'h0, 1'b1), 0, '0);
    add(mk(REQ_READ, 32'h0, 13'h0, 1'b0), 0, '0);
    add(mk(REQ_SCALAR, 32'h77, 13'h0, 1'b0), 0, '0);
    add(mk(REQ_BASE, 32'h0, 13'h0, 1'b0), 0, '0);
    add(mk(REQ_BASE, 32'h80000001, 13'h0, 1'b1), 0, '0);
    add(mk(REQ_READ, 32'h0, 13'h0, 1'b1), 0, '0);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (drows[k]) begin
      send(drows[k].r, got, o);
      if (drows[k].chk && (got !== 1'b1 || o !== drows[k].exp)) begin
        errors++;
        $display("%0t directed row %0d: exp st=%0d data=%h got st=%0d data=%h", $time, k,
                 drows[k].exp.status_code, drows[k].exp.data_word, o.status_code, o.data_word);
      end
    end
    settle();

    while (items < ITEM_TARGET) run_phase();

    repeat (20) @(posedge clk);
    if (errors == 0 && pending_words.size() == 0) begin
      $display("PASS matrix_submatrix_and_indexed_fill");
    end else begin
      $display("FAIL matrix_submatrix_and_indexed_fill");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/msif_pkg.sv
sv/msif_ram.sv
sv/msif_ctrl.sv
sv/msif_dp.sv
sv/matrix_submatrix_and_indexed_fill.sv
sv/msif_chk.sv
test/tb_top.sv
